// ===== sv/rmst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the range-minimum sparse table block.
// No dependencies; used by rmst_ctrl, the top and the bench.
package rmst_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned IDX_FIELD_W = 10;
  localparam int unsigned IN_TDATA_W  = 56;  // value, left, right, zero pad to bytes
  localparam int unsigned OUT_TDATA_W = 32;

  // Operation codes carried in s_axis_tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_LVL,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_QRY
  } state_e;

  typedef struct packed {
    state_e state;
    logic   table_ready;
  } stat_t;

endpackage

// ===== sv/rmst_mem.sv =====
`timescale 1ns / 1ps
// Level storage of the sparse table: one write port, two registered read ports.
// No dependencies.
module rmst_mem #(
  parameter int unsigned DEPTH  = 11264,
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/rmst_min.sv =====
`timescale 1ns / 1ps
// Shared signed minimum unit, used by both the table build and the queries.
// No dependencies.
module rmst_min #(
  parameter int unsigned DATA_W = 32
) (
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic signed [DATA_W-1:0] min_o
);

  // ties pick a, as the build and query merges expect
  assign min_o = (a_i <= b_i) ? a_i : b_i;

endmodule

// ===== sv/rmst_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for loads, table build and queries, plus the result register.
// Depends on rmst_pkg.
module rmst_ctrl #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11,
  parameter int unsigned DATA_WIDTH   = 32,
  parameter int unsigned ADDR_W       = $clog2(LEVELS * MAX_ELEMENTS)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  in_op_i,
  input  logic signed [rmst_pkg::VALUE_W-1:0]   in_value_i,
  input  logic                                  in_last_i,
  input  logic [rmst_pkg::IDX_FIELD_W-1:0]      in_left_i,
  input  logic [rmst_pkg::IDX_FIELD_W-1:0]      in_right_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rmst_pkg::VALUE_W-1:0]   out_min_o,
  output logic                                  out_err_o,
  output logic                                  mem_we_o,
  output logic [ADDR_W-1:0]                     mem_waddr_o,
  output logic [DATA_WIDTH-1:0]                 mem_wdata_o,
  output logic [ADDR_W-1:0]                     mem_raddr_a_o,
  output logic [ADDR_W-1:0]                     mem_raddr_b_o,
  input  logic signed [DATA_WIDTH-1:0]          min_i,
  output rmst_pkg::stat_t                       stat_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LVL_W = $clog2(LEVELS + 1);
  localparam int unsigned IDX_W = rmst_pkg::IDX_FIELD_W;
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned LEN_W = IDX_W + 1;
  localparam int unsigned LOG_W = $clog2(LEN_W);

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [CMP_W-1:0] idx);
    tbl_addr = ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(idx);
  endfunction

  rmst_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ready_q, ready_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] qa_q, qa_d, qb_q, qb_d;
  logic              out_valid_q, out_valid_d;
  logic signed [rmst_pkg::VALUE_W-1:0] out_min_q, out_min_d;
  logic              out_err_q, out_err_d;

  logic              accept;
  logic              q_err;
  logic [LEN_W-1:0]  len;
  logic [LOG_W-1:0]  lg;
  logic [LVL_W-1:0]  k;
  logic [LEN_W-1:0]  second;
  logic [CNT_W-1:0]  cnt_base;
  logic              room;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  left_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmst_pkg::ST_IDLE;
      count_q     <= '0;
      ready_q     <= 1'b0;
      lvl_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ready_q     <= ready_d;
      lvl_q       <= lvl_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qa_q      <= qa_d;
    qb_q      <= qb_d;
    out_min_q <= out_min_d;
    out_err_q <= out_err_d;
  end

  // Query decode: bounds check, floor log2 of the length, second window start
  always_comb begin
    q_err = !ready_q || (in_left_i > in_right_i) ||
            (CMP_W'(in_right_i) >= CMP_W'(count_q));
    len   = LEN_W'(in_right_i) - LEN_W'(in_left_i) + LEN_W'(1);
    lg    = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (len[b]) begin
        lg = LOG_W'(b);
      end
    end
    if (int'(lg) > LEVELS - 1) begin
      k = LVL_W'(LEVELS - 1);
    end else begin
      k = LVL_W'(lg);
    end
    second = LEN_W'(in_right_i) + LEN_W'(1) - (LEN_W'(1) << k);
  end

  always_comb begin
    cnt_base = ready_q ? '0 : count_q;
    room     = cnt_base < CNT_W'(MAX_ELEMENTS);
    half     = CNT_W'(1) << (lvl_q - LVL_W'(1));
    left_cnt = count_q - idx_q - CNT_W'(1);
  end

  assign in_ready_o = (state_q == rmst_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ready_d     = ready_q;
    lvl_d       = lvl_q;
    idx_d       = idx_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_min_d   = out_min_q;
    out_err_d   = out_err_q;

    mem_we_o      = 1'b0;
    mem_waddr_o   = tbl_addr('0, CMP_W'(cnt_base));
    mem_wdata_o   = DATA_WIDTH'(in_value_i);
    mem_raddr_a_o = tbl_addr(k, CMP_W'(in_left_i));
    mem_raddr_b_o = tbl_addr(k, CMP_W'(second));

    case (state_q)
      rmst_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op_i == rmst_pkg::OP_LOAD) begin
            ready_d  = 1'b0;
            mem_we_o = room;
            count_d  = room ? cnt_base + CNT_W'(1) : cnt_base;
            if (in_last_i) begin
              lvl_d   = LVL_W'(1);
              state_d = rmst_pkg::ST_BLD_LVL;
            end
          end else if (q_err) begin
            out_valid_d = 1'b1;
            out_min_d   = '0;
            out_err_d   = 1'b1;
          end else begin
            qa_d    = mem_raddr_a_o;
            qb_d    = mem_raddr_b_o;
            state_d = rmst_pkg::ST_QRY;
          end
        end
      end
      rmst_pkg::ST_BLD_LVL: begin
        if ((lvl_q == LVL_W'(LEVELS)) || ((count_q >> lvl_q) == '0)) begin
          ready_d = 1'b1;
          state_d = rmst_pkg::ST_IDLE;
        end else begin
          idx_d   = '0;
          state_d = rmst_pkg::ST_BLD_RD;
        end
      end
      rmst_pkg::ST_BLD_RD: begin
        mem_raddr_a_o = tbl_addr(lvl_q - LVL_W'(1), CMP_W'(idx_q));
        mem_raddr_b_o = tbl_addr(lvl_q - LVL_W'(1), CMP_W'(idx_q + half));
        state_d       = rmst_pkg::ST_BLD_WR;
      end
      rmst_pkg::ST_BLD_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tbl_addr(lvl_q, CMP_W'(idx_q));
        mem_wdata_o = min_i;
        // another entry fits at this level while idx + 1 + 2^k <= count
        if ((left_cnt >> lvl_q) != '0) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = rmst_pkg::ST_BLD_RD;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = rmst_pkg::ST_BLD_LVL;
        end
      end
      rmst_pkg::ST_QRY: begin
        // read data of the two windows is ready; output slot drained at accept
        mem_raddr_a_o = qa_q;
        mem_raddr_b_o = qb_q;
        out_valid_d   = 1'b1;
        out_min_d     = rmst_pkg::VALUE_W'(min_i);
        out_err_d     = 1'b0;
        state_d       = rmst_pkg::ST_IDLE;
      end
      default: begin
        state_d = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign out_min_o          = out_min_q;
  assign out_err_o          = out_err_q;
  assign stat_o.state       = state_q;
  assign stat_o.table_ready = ready_q;

endmodule

// ===== sv/range_minimum_sparse_table_top.sv =====
`timescale 1ns / 1ps
// Range-minimum sparse table: a load writes the next level-0 entry while there is room; a valid
// query is a registered memory read of two windows, then one compare; an invalid query goes
// straight to the result register. The load marked tlast starts a build during which the
// block takes no transaction: each level k below LEVELS with 2^k <= n, for n loaded elements,
// is built entry by entry, a read of two entries of the level below then a write of their min,
// through the single shared compare unit fed from the two read ports of the level memory.
// The memory has no clearing pass; valid queries only read entries the loads or build wrote.
// Depends on rmst_pkg, rmst_ctrl, rmst_mem and rmst_min.
module range_minimum_sparse_table_top #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // value[31:0], left_index[41:32], right_index[51:42], zero pad [55:52]
  input  logic [rmst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tlast,
  // operation[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // minimum[31:0]
  output logic [rmst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // range_error[0]
  output logic                                m_axis_tuser
);

  localparam int unsigned DEPTH  = LEVELS * MAX_ELEMENTS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic                                 mem_we;
  logic [ADDR_W-1:0]                    mem_waddr;
  logic [DATA_WIDTH-1:0]                mem_wdata;
  logic [ADDR_W-1:0]                    mem_raddr_a;
  logic [ADDR_W-1:0]                    mem_raddr_b;
  logic [DATA_WIDTH-1:0]                mem_rdata_a;
  logic [DATA_WIDTH-1:0]                mem_rdata_b;
  logic signed [DATA_WIDTH-1:0]         min_val;
  logic signed [rmst_pkg::VALUE_W-1:0]  in_value;
  logic signed [rmst_pkg::VALUE_W-1:0]  out_min;
  rmst_pkg::stat_t                      stat;

  assign in_value     = s_axis_tdata[31:0];
  assign m_axis_tdata = out_min;

  rmst_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .DATA_WIDTH   (DATA_WIDTH),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (s_axis_tuser),
    .in_value_i    (in_value),
    .in_last_i     (s_axis_tlast),
    .in_left_i     (s_axis_tdata[41:32]),
    .in_right_i    (s_axis_tdata[51:42]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_min_o     (out_min),
    .out_err_o     (m_axis_tuser),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .min_i         (min_val),
    .stat_o        (stat)
  );

  rmst_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  rmst_min #(
    .DATA_W (DATA_WIDTH)
  ) u_min (
    .a_i   (mem_rdata_a),
    .b_i   (mem_rdata_b),
    .min_o (min_val)
  );

`ifndef SYNTHESIS
  // memory is written only by an accepted load or by the build write step
  a_mem_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((s_axis_tvalid && s_axis_tready && s_axis_tuser == rmst_pkg::OP_LOAD) ||
                stat.state == rmst_pkg::ST_BLD_WR))
    else $error("level memory written outside load or build");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> stat.state == rmst_pkg::ST_IDLE)
    else $error("ready raised while sequencer busy");

  a_qry_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.state == rmst_pkg::ST_QRY |=> m_axis_tvalid && !m_axis_tuser)
    else $error("query lookup gave no result");

  a_no_table_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == rmst_pkg::OP_QUERY &&
     !stat.table_ready) |=> m_axis_tvalid && m_axis_tuser && m_axis_tdata == '0)
    else $error("query without table not flagged");
`endif

endmodule

// ===== dv/range_minimum_sparse_table_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for range_minimum_sparse_table_top: loads arrays, asks range-minimum
// queries and checks every answer against a brute-force minimum scan of the held array.
// Depends on rmst_pkg and the block's RTL.
module range_minimum_sparse_table_top_test;

  localparam int unsigned MAX_ELEMENTS      = 1024;
  localparam int unsigned LEVELS            = 11;
  localparam int unsigned DATA_WIDTH        = 32;
  localparam int unsigned LONG_STALL_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT       = 100000;
  localparam int unsigned PAD_W             = rmst_pkg::IN_TDATA_W
                                              - 2 * rmst_pkg::IDX_FIELD_W
                                              - rmst_pkg::VALUE_W;

  typedef struct {
    logic                                op;
    logic signed [rmst_pkg::VALUE_W-1:0] value;
    logic                                last;
    logic [rmst_pkg::IDX_FIELD_W-1:0]    left_idx;
    logic [rmst_pkg::IDX_FIELD_W-1:0]    right_idx;
  } rmq_item_t;

  typedef struct {
    logic signed [rmst_pkg::VALUE_W-1:0] minimum;
    logic                                range_error;
  } range_min_t;

  // Mirrors the held array and answers each query by scanning it directly.
  class range_min_scoreboard;
    logic signed [rmst_pkg::VALUE_W-1:0] held_values[MAX_ELEMENTS];
    int unsigned               held_count;
    bit                        table_built;
    range_min_t                pending_minima[$];
    int unsigned               errors, loads, dropped, builds, queries, range_errors, checked;

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function range_min_t predict_query(logic [rmst_pkg::IDX_FIELD_W-1:0] l,
                                       logic [rmst_pkg::IDX_FIELD_W-1:0] r);
      range_min_t m;
      m.minimum     = '0;
      m.range_error = 1'b1;
      if (table_built && l <= r && r < held_count) begin
        m.range_error = 1'b0;
        m.minimum     = held_values[l];
        for (int i = l + 1; i <= r; i++) begin
          if (held_values[i] < m.minimum) m.minimum = held_values[i];
        end
      end
      return m;
    endfunction

    function void note_accepted(rmq_item_t it);
      range_min_t m;
      if (it.op == rmst_pkg::OP_LOAD) begin
        loads++;
        // a load after a build starts a fresh array
        if (table_built) begin
          table_built = 1'b0;
          held_count  = 0;
        end
        if (held_count < MAX_ELEMENTS) begin
          held_values[held_count] = it.value;
          held_count++;
        end else begin
          dropped++;
        end
        if (it.last) begin
          table_built = 1'b1;
          builds++;
        end
      end else begin
        queries++;
        m = predict_query(it.left_idx, it.right_idx);
        if (m.range_error) range_errors++;
        pending_minima.push_back(m);
      end
    endfunction

    task check_result(logic [rmst_pkg::OUT_TDATA_W-1:0] minimum, logic range_error);
      range_min_t want;
      if (pending_minima.size() == 0) begin
        report($sformatf("result %h / error %b with no query outstanding", minimum, range_error));
        return;
      end
      want = pending_minima.pop_front();
      checked++;
      if (minimum !== want.minimum)
        report($sformatf("minimum %h, expected %h", minimum, want.minimum));
      if (range_error !== want.range_error)
        report($sformatf("range_error %b, expected %b", range_error, want.range_error));
    endtask
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [rmst_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                             s_axis_tlast;
  logic                             s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [rmst_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;

  range_min_scoreboard sb;
  int unsigned         items_sent;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         stalls_requested;
  int unsigned         stalls_served;
  int unsigned         hold_left;

  range_minimum_sparse_table_top #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random back-pressure plus an occasional long hold-off.
  initial begin
    m_axis_tready    = 1'b0;
    stalls_served    = 0;
    hold_left        = 0;
    forever begin
      @(negedge clk_i);
      if (stalls_served != stalls_requested) begin
        stalls_served++;
        hold_left = LONG_STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Called just after a falling edge; returns just after the one that follows acceptance.
  task automatic drive_item(input rmq_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {{PAD_W{1'b0}}, it.right_idx, it.left_idx, it.value};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_accepted(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_load(input logic signed [rmst_pkg::VALUE_W-1:0] v, input logic lst);
    rmq_item_t it;
    it.op        = rmst_pkg::OP_LOAD;
    it.value     = v;
    it.last      = lst;
    it.left_idx  = rmst_pkg::IDX_FIELD_W'($urandom);
    it.right_idx = rmst_pkg::IDX_FIELD_W'($urandom);
    drive_item(it);
  endtask

  task automatic send_query(input logic [rmst_pkg::IDX_FIELD_W-1:0] l,
                            input logic [rmst_pkg::IDX_FIELD_W-1:0] r);
    rmq_item_t it;
    it.op        = rmst_pkg::OP_QUERY;
    it.value     = $urandom;
    it.last      = 1'($urandom_range(1));
    it.left_idx  = l;
    it.right_idx = r;
    drive_item(it);
  endtask

  function automatic logic signed [rmst_pkg::VALUE_W-1:0] pick_value(input int unsigned style);
    int unsigned sel;
    sel = $urandom_range(5);
    if (style == 0) return $urandom_range(15) - 8;  // narrow spread, many ties
    if (style == 1) begin
      if (sel == 0) return 32'sh7fff_ffff;
      if (sel == 1) return 32'sh8000_0000;
      if (sel == 2) return '0;
      if (sel == 3) return '1;
    end
    return $urandom;
  endfunction

  function automatic int unsigned pick_size();
    if ($urandom_range(99) < 7) return $urandom_range(128, 17);
    return $urandom_range(16, 1);
  endfunction

  task automatic send_random_query(input int unsigned span);
    int unsigned kind, l, r;
    kind = $urandom_range(99);
    if (kind < 58) begin
      l = $urandom_range(span - 1);
      r = $urandom_range(span - 1, l);
    end else if (kind < 68) begin
      l = 0;
      r = span - 1;
    end else if (kind < 76) begin
      l = $urandom_range(span - 1);
      r = l;
    end else if (kind < 85) begin
      l = $urandom_range(1023, 1);
      r = $urandom_range(l - 1);
    end else if (kind < 93 && span < MAX_ELEMENTS) begin
      r = $urandom_range(1023, span);
      l = $urandom_range(r);
    end else begin
      l = $urandom_range(1023);
      r = $urandom_range(1023);
    end
    send_query(l[rmst_pkg::IDX_FIELD_W-1:0], r[rmst_pkg::IDX_FIELD_W-1:0]);
  endtask

  // One array: loads (the last one usually marked) with an occasional query among them, then queries.
  task automatic run_array(input int unsigned n, input int unsigned n_queries);
    int unsigned style, span;
    bit          mark_last;
    style     = $urandom_range(2);
    mark_last = ($urandom_range(9) != 0);
    span      = (n < MAX_ELEMENTS) ? n : MAX_ELEMENTS;
    for (int unsigned i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(39) == 0) send_random_query(span);
      send_load(pick_value(style), mark_last && i == n - 1);
    end
    repeat (n_queries) send_random_query(span);
  endtask

  task automatic run_directed();
    send_query(0, 0);               // nothing built yet
    send_load(32'sh7fff_ffff, 1'b0);
    send_query(0, 0);               // array still loading
    send_load(32'sh8000_0000, 1'b0);
    send_load('0, 1'b0);
    send_load('1, 1'b1);            // builds four elements
    send_query(0, 3);
    send_query(0, 0);
    send_query(2, 3);
    send_query(1, 2);
    send_query(3, 3);
    send_query(0, 1);
    send_query(2, 1);               // left above right
    send_query(0, 4);               // right past the count
    send_query(1023, 1023);
    send_query(0, 1023);
    send_load(5, 1'b1);             // new array of one
    send_query(0, 0);
    send_query(0, 1);
    send_load(-7, 1'b0);
    send_load(9, 1'b0);
    send_load(-7, 1'b1);
    send_query(0, 2);
    send_query(1, 1);
    send_query(1, 2);
  endtask

  initial begin
    #5_000_000;
    $display("range_minimum_sparse_table_top regression: fail");
    $finish;
  end

  initial begin
    sb               = new();
    items_sent       = 0;
    stalls_requested = 0;
    send_idle_pct    = 24;
    recv_idle_pct    = 46;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tlast     = 1'b0;
    s_axis_tuser     = rmst_pkg::OP_LOAD;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    while (items_sent < 470) run_array(pick_size(), $urandom_range(16, 4));

    send_idle_pct = 46;
    recv_idle_pct = 24;
    // past capacity: the extra loads are dropped, the marked one still builds
    run_array(MAX_ELEMENTS + $urandom_range(4, 1), 48);
    while (items_sent < 1560) run_array(pick_size(), $urandom_range(16, 4));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_array(24, 0);
    stalls_requested++;
    repeat (32) send_random_query(24);
    while (items_sent < 1950) run_array(pick_size(), $urandom_range(16, 4));
    s_axis_tvalid <= 1'b0;

    for (int c = 0; c < DRAIN_LIMIT && sb.pending_minima.size() != 0; c++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.pending_minima.size() != 0)
      sb.report($sformatf("%0d queries never answered", sb.pending_minima.size()));

    $display("covered %0d loads (%0d past capacity), %0d builds, %0d queries (%0d range errors)",
             sb.loads, sb.dropped, sb.builds, sb.queries, sb.range_errors);
    $display("%0d results checked over three idling phases and a %0d-cycle receiver hold-off",
             sb.checked, LONG_STALL_CYCLES);
    if (sb.errors == 0) begin
      $display("range_minimum_sparse_table_top regression: pass");
    end else begin
      $display("range_minimum_sparse_table_top regression: fail");
    end
    $finish;
  end

endmodule
